/* sv/ptsched_pkg.sv */
// Package for the priority task scheduler.
// Holds sizes, request operation codes, register indexes and the sequencer state type.
// No dependencies.
`default_nettype none

package ptsched_pkg;

   localparam int NUM_TASKS  = 8;
   localparam int TASK_BITS  = 3;
   localparam int PRIO_BITS  = 3;
   localparam int TICK_BITS  = 32;
   localparam int COUNT_BITS = 4;

   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_DELAY  = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_SWITCH = 2'd3;

   localparam logic CSR_PREEMPT    = 1'b0;
   localparam logic CSR_TIME_SLICE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DLY_WRAP,
      ST_DLY_NU,
      ST_MIN_A,
      ST_CHECK,
      ST_WAKE,
      ST_MIN_C,
      ST_SLICE,
      ST_SEL_MAX,
      ST_SEL_RR,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

/* sv/ptsched_if.sv */
// Valid/ready channels of the priority task scheduler: request and response.
// Depends on ptsched_pkg for field widths.
`default_nettype none

interface ptsched_req_if import ptsched_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           op;
   logic [TASK_BITS-1:0] task_id;
   logic [PRIO_BITS-1:0] task_priority_in;
   logic [TICK_BITS-1:0] delay_ticks;

   modport source (output valid, op, task_id, task_priority_in, delay_ticks, input ready);
   modport sink (input valid, op, task_id, task_priority_in, delay_ticks, output ready);
endinterface

interface ptsched_rsp_if import ptsched_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [TASK_BITS-1:0]  current_task;
   logic                  current_valid;
   logic                  switch_required;
   logic [TICK_BITS-1:0]  tick_now;
   logic [COUNT_BITS-1:0] woken_count;

   modport source (output valid, current_task, current_valid, switch_required, tick_now,
                   woken_count, input ready);
   modport sink (input valid, current_task, current_valid, switch_required, tick_now,
                 woken_count, output ready);
endinterface

`default_nettype wire

/* sv/priority_task_scheduler_core.sv */
// Priority task scheduler core: one sequencer with a shared adder and a shared comparator.
// Depends on ptsched_pkg and the channel interfaces in ptsched_if.sv.
//
// Usage: each request on req_chan carries op, task_id, task_priority_in and delay_ticks.
// Every request gives exactly one response on rsp_chan with the current task, a switch
// flag, the tick counter and the number of tasks woken by a tick.
// The configuration port writes preempt_enable (index 0) and time_slice_enable (index 1);
// the user must write it only while the block is idle; the block itself does not enforce this.
// A create goes from the idle state straight to the finishing state; a delay, a switch
// and a tick may pass through scans of the task slots first. Each scan visits one task
// slot per cycle; the wake-time comparisons share the single comparator. A request is accepted
// only in the idle state, which follows the loading cycle, so a new request is not taken
// before the last one has loaded the response register.
// The response register holds a finished response while the receiver stalls; the next
// request may still be accepted and worked on, and its response waits until the
// register is free.
// Reset is synchronous: all tasks are cleared, the tick counter is zero, the next
// unblock time is all ones and both enables are set.
`default_nettype none

module priority_task_scheduler_core import ptsched_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   ptsched_req_if.sink   req_chan,
   ptsched_rsp_if.source rsp_chan,
   input  wire logic csr_write_enable,
   input  wire logic csr_index,
   input  wire logic csr_write_data
);

   state_type state_ff, state_in;

   logic [NUM_TASKS-1:0] ready_ff, ready_in;
   logic [NUM_TASKS-1:0] delayed_ff, delayed_in;
   logic [NUM_TASKS-1:0] ovf_ff, ovf_in;
   logic [PRIO_BITS-1:0] prio_ff [NUM_TASKS];
   logic [PRIO_BITS-1:0] prio_in [NUM_TASKS];
   logic [TASK_BITS-1:0] rr_ff [NUM_TASKS];
   logic [TASK_BITS-1:0] rr_in [NUM_TASKS];
   logic [TICK_BITS-1:0] wake_ff [NUM_TASKS];

   logic [TASK_BITS-1:0] rt_ff, rt_in;
   logic                 rv_ff, rv_in;
   logic [TICK_BITS-1:0] tick_ff, tick_in;
   logic [TICK_BITS-1:0] nu_ff, nu_in;
   logic [TICK_BITS-1:0] min_ff, min_in;
   logic [TICK_BITS-1:0] w_ff, w_in;
   logic [TASK_BITS-1:0] idx_ff, idx_in;
   logic [TASK_BITS-1:0] k_ff, k_in;
   logic [PRIO_BITS-1:0] best_ff, best_in;
   logic                 found_ff, found_in;
   logic                 sw_ff, sw_in;
   logic [COUNT_BITS-1:0] woken_ff, woken_in;
   logic                 preempt_ff, slice_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TASK_BITS-1:0]  rsp_task_ff;
   logic                  rsp_cv_ff, rsp_sw_ff;
   logic [TICK_BITS-1:0]  rsp_tick_ff;
   logic [COUNT_BITS-1:0] rsp_woken_ff;

   logic                 accept, last, lt, out_free, load_rsp, hit, wake_we;
   logic [TICK_BITS-1:0] sum, cmp_a, cmp_b, wake_rd;
   logic [TASK_BITS-1:0] cand;
   logic [PRIO_BITS-1:0] cur_prio;
   logic [COUNT_BITS-1:0] same_count;

   assign accept   = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign last     = (idx_ff == TASK_BITS'(NUM_TASKS - 1));
   assign sum      = tick_ff + ((req_chan.op == OP_TICK) ? TICK_BITS'(1) : req_chan.delay_ticks);
   assign wake_rd  = wake_ff[idx_ff];
   assign lt       = (cmp_a < cmp_b);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign load_rsp = (state_ff == ST_FINISH) && out_free;
   assign cand     = rr_ff[best_ff] + k_ff;
   assign hit      = ready_ff[cand] && (prio_ff[cand] == best_ff);
   assign cur_prio = prio_ff[rt_ff];
   assign wake_we  = accept && (req_chan.op == OP_DELAY) && rv_ff;

   always_comb begin
      cmp_a = tick_ff;
      cmp_b = tick_ff;
      unique case (state_ff)
         ST_DLY_WRAP: begin cmp_a = w_ff;    cmp_b = tick_ff; end
         ST_DLY_NU:   begin cmp_a = w_ff;    cmp_b = nu_ff;   end
         ST_MIN_A, ST_MIN_C: begin cmp_a = wake_rd; cmp_b = min_ff; end
         ST_CHECK:    begin cmp_a = tick_ff; cmp_b = nu_ff;   end
         ST_WAKE:     begin cmp_a = tick_ff; cmp_b = wake_rd; end
         default:     begin cmp_a = tick_ff; cmp_b = tick_ff; end
      endcase
   end

   always_comb begin
      same_count = '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
         if (ready_ff[i] && (prio_ff[i] == cur_prio)) same_count = same_count + 1'b1;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_chan.op)
                  OP_CREATE: state_in = ST_FINISH;
                  OP_DELAY:  state_in = rv_ff ? ST_DLY_WRAP : ST_FINISH;
                  OP_TICK:   state_in = (sum == '0) ? ST_MIN_A : ST_CHECK;
                  default:   state_in = ST_SEL_MAX;
               endcase
            end
         end
         ST_DLY_WRAP: state_in = lt ? ST_SEL_MAX : ST_DLY_NU;
         ST_DLY_NU:   state_in = ST_SEL_MAX;
         ST_MIN_A:    if (last) state_in = ST_CHECK;
         ST_CHECK:    state_in = lt ? ST_SLICE : ST_WAKE;
         ST_WAKE:     if (last) state_in = ST_MIN_C;
         ST_MIN_C:    if (last) state_in = ST_SLICE;
         ST_SLICE:    state_in = ST_FINISH;
         ST_SEL_MAX:  if (last) state_in = found_in ? ST_SEL_RR : ST_FINISH;
         ST_SEL_RR:   if (hit) state_in = ST_FINISH;
         ST_FINISH:   if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath and task state updates.
   always_comb begin
      ready_in = ready_ff;
      delayed_in = delayed_ff;
      ovf_in = ovf_ff;
      prio_in = prio_ff;
      rr_in = rr_ff;
      rt_in = rt_ff;
      rv_in = rv_ff;
      tick_in = tick_ff;
      nu_in = nu_ff;
      min_in = min_ff;
      w_in = w_ff;
      idx_in = idx_ff + 1'b1;
      k_in = k_ff;
      best_in = best_ff;
      found_in = found_ff;
      sw_in = sw_ff;
      woken_in = woken_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (accept) begin
               sw_in = 1'b0;
               woken_in = '0;
               found_in = 1'b0;
               min_in = '1;
               unique case (req_chan.op)
                  OP_CREATE: begin
                     delayed_in[req_chan.task_id] = 1'b0;
                     ovf_in[req_chan.task_id] = 1'b0;
                     prio_in[req_chan.task_id] = req_chan.task_priority_in;
                     ready_in[req_chan.task_id] = 1'b1;
                     if (!rv_ff || rt_ff == req_chan.task_id ||
                         cur_prio <= req_chan.task_priority_in) begin
                        rt_in = req_chan.task_id;
                        rv_in = 1'b1;
                     end
                  end
                  OP_DELAY: begin
                     w_in = sum;
                     if (rv_ff) ready_in[rt_ff] = 1'b0;
                  end
                  OP_TICK: begin
                     tick_in = sum;
                     if (sum == '0) begin
                        delayed_in = ovf_ff;
                        ovf_in = delayed_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DLY_WRAP: begin
            idx_in = '0;
            if (lt) ovf_in[rt_ff] = 1'b1;
            else delayed_in[rt_ff] = 1'b1;
         end
         ST_DLY_NU: begin
            idx_in = '0;
            if (lt) nu_in = w_ff;
         end
         ST_MIN_A, ST_MIN_C: begin
            if (delayed_ff[idx_ff] && lt) min_in = wake_rd;
            if (last) nu_in = (delayed_ff[idx_ff] && lt) ? wake_rd : min_ff;
         end
         ST_CHECK: begin
            idx_in = '0;
         end
         ST_WAKE: begin
            if (delayed_ff[idx_ff] && !lt) begin
               delayed_in[idx_ff] = 1'b0;
               ready_in[idx_ff] = 1'b1;
               woken_in = woken_ff + 1'b1;
               if (preempt_ff && (!rv_ff || prio_ff[idx_ff] >= cur_prio)) sw_in = 1'b1;
            end
            if (last) min_in = '1;
         end
         ST_SLICE: begin
            if (preempt_ff && slice_ff && rv_ff && same_count > COUNT_BITS'(1)) sw_in = 1'b1;
         end
         ST_SEL_MAX: begin
            if (ready_ff[idx_ff] && (!found_ff || prio_ff[idx_ff] > best_ff)) begin
               best_in = prio_ff[idx_ff];
               found_in = 1'b1;
            end
            k_in = TASK_BITS'(1);
            if (last && !found_in) begin
               rt_in = '0;
               rv_in = 1'b0;
            end
         end
         ST_SEL_RR: begin
            k_in = k_ff + 1'b1;
            if (hit) begin
               rr_in[best_ff] = cand;
               rt_in = cand;
               rv_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) rsp_valid_in = 1'b0;
      if (load_rsp) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= '0;
         delayed_ff <= '0;
         ovf_ff <= '0;
         for (int i = 0; i < NUM_TASKS; i++) begin
            prio_ff[i] <= '0;
            rr_ff[i] <= '0;
         end
         rt_ff <= '0;
         rv_ff <= 1'b0;
         tick_ff <= '0;
         nu_ff <= '1;
         rsp_valid_ff <= 1'b0;
         preempt_ff <= 1'b1;
         slice_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         delayed_ff <= delayed_in;
         ovf_ff <= ovf_in;
         prio_ff <= prio_in;
         rr_ff <= rr_in;
         rt_ff <= rt_in;
         rv_ff <= rv_in;
         tick_ff <= tick_in;
         nu_ff <= nu_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_PREEMPT:    preempt_ff <= csr_write_data;
               CSR_TIME_SLICE: slice_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      min_ff <= min_in;
      w_ff <= w_in;
      idx_ff <= idx_in;
      k_ff <= k_in;
      best_ff <= best_in;
      found_ff <= found_in;
      sw_ff <= sw_in;
      woken_ff <= woken_in;
      if (wake_we) wake_ff[rt_ff] <= sum;
      if (load_rsp) begin
         rsp_task_ff <= rv_ff ? rt_ff : '0;
         rsp_cv_ff <= rv_ff;
         rsp_sw_ff <= sw_ff;
         rsp_tick_ff <= tick_ff;
         rsp_woken_ff <= woken_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.current_task = rsp_task_ff;
   assign rsp_chan.current_valid = rsp_cv_ff;
   assign rsp_chan.switch_required = rsp_sw_ff;
   assign rsp_chan.tick_now = rsp_tick_ff;
   assign rsp_chan.woken_count = rsp_woken_ff;

`ifndef ASSERT_OFF
   a_running_is_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && rv_ff) |-> ready_ff[rt_ff])
      else $error("Running task is not ready while idle.");

   a_one_delay_set: assert property (@(posedge clock) disable iff (reset)
      (delayed_ff & ovf_ff) == '0)
      else $error("Task is in both delay sets.");
`endif

endmodule

`default_nettype wire

/* verif/tb_priority_task_scheduler_core.sv */
// Self-checking testbench for the priority task scheduler core.
// Drives scheduler requests and configuration writes, predicts every response and compares.
// Depends on ptsched_pkg, ptsched_if.sv and priority_task_scheduler_core.
`default_nettype none

module tb_priority_task_scheduler_core;
   import ptsched_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [TASK_BITS-1:0]  current_task;
      logic                  current_valid;
      logic                  switch_required;
      logic [TICK_BITS-1:0]  tick_now;
      logic [COUNT_BITS-1:0] woken_count;
   } sched_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_index = 1'b0;
   logic csr_write_data = 1'b0;

   ptsched_req_if req_chan ();
   ptsched_rsp_if rsp_chan ();

   priority_task_scheduler_core u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #2 clock = ~clock;

   // Scheduler state mirror.
   logic [PRIO_BITS-1:0] task_prio [NUM_TASKS];
   logic                 task_ready [NUM_TASKS];
   logic                 in_main_set [NUM_TASKS];
   logic                 in_wrap_set [NUM_TASKS];
   logic [TICK_BITS-1:0] wake_at [NUM_TASKS];
   logic [TASK_BITS-1:0] rr_last [NUM_TASKS];
   logic [TASK_BITS-1:0] run_task;
   logic                 run_valid;
   logic [TICK_BITS-1:0] ticks;
   logic [TICK_BITS-1:0] next_wake;
   logic                 preempt_on;
   logic                 slice_on;

   sched_rsp_type pending_rsp [$];
   int error_count = 0;
   int cycle_count = 0;
   bit stall_often = 1'b0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("Mismatch in %s: got %0h, expected %0h", what, got, want);
      error_count++;
   endtask

   function automatic int ready_count(input logic [PRIO_BITS-1:0] p);
      int n;
      n = 0;
      for (int i = 0; i < NUM_TASKS; i++) if (task_ready[i] && task_prio[i] == p) n++;
      return n;
   endfunction

   function automatic logic [TICK_BITS-1:0] earliest_wake();
      logic [TICK_BITS-1:0] m;
      m = '1;
      for (int i = 0; i < NUM_TASKS; i++) if (in_main_set[i] && wake_at[i] < m) m = wake_at[i];
      return m;
   endfunction

   function automatic void pick_task();
      int idx;
      for (int p = NUM_TASKS - 1; p >= 0; p--) begin
         if (ready_count(PRIO_BITS'(p)) == 0) continue;
         for (int k = 1; k <= NUM_TASKS; k++) begin
            idx = (rr_last[p] + k) % NUM_TASKS;
            if (task_ready[idx] && task_prio[idx] == p) begin
               rr_last[p] = TASK_BITS'(idx);
               run_task = TASK_BITS'(idx);
               run_valid = 1'b1;
               return;
            end
         end
      end
      run_task = '0;
      run_valid = 1'b0;
   endfunction

   function automatic void clear_schedule();
      for (int i = 0; i < NUM_TASKS; i++) begin
         task_prio[i] = '0; task_ready[i] = 0; in_main_set[i] = 0; in_wrap_set[i] = 0;
         wake_at[i] = '0; rr_last[i] = '0;
      end
      run_task = '0; run_valid = 0; ticks = '0; next_wake = '1;
      preempt_on = 1; slice_on = 1;
   endfunction

   function automatic sched_rsp_type schedule_step(input logic [1:0] op,
         input logic [TASK_BITS-1:0] id, input logic [PRIO_BITS-1:0] pr,
         input logic [TICK_BITS-1:0] dly);
      sched_rsp_type r;
      logic sw;
      logic t;
      logic [TICK_BITS-1:0] w;
      int woken;
      sw = 0;
      woken = 0;
      case (op)
         OP_CREATE: begin
            in_main_set[id] = 0;
            in_wrap_set[id] = 0;
            task_prio[id] = pr;
            if (!run_valid || task_prio[run_task] <= pr) begin
               run_task = id;
               run_valid = 1;
            end
            task_ready[id] = 1;
         end
         OP_DELAY: begin
            if (run_valid) begin
               w = ticks + dly;
               task_ready[run_task] = 0;
               wake_at[run_task] = w;
               if (w < ticks) begin
                  in_wrap_set[run_task] = 1;
               end else begin
                  in_main_set[run_task] = 1;
                  if (w < next_wake) next_wake = w;
               end
               pick_task();
            end
         end
         OP_TICK: begin
            ticks = ticks + TICK_BITS'(1);
            if (ticks == 0) begin
               for (int i = 0; i < NUM_TASKS; i++) begin
                  t = in_main_set[i];
                  in_main_set[i] = in_wrap_set[i];
                  in_wrap_set[i] = t;
               end
               next_wake = earliest_wake();
            end
            if (ticks >= next_wake) begin
               for (int i = 0; i < NUM_TASKS; i++) begin
                  if (in_main_set[i] && wake_at[i] <= ticks) begin
                     in_main_set[i] = 0;
                     task_ready[i] = 1;
                     woken++;
                     if (preempt_on && (!run_valid || task_prio[i] >= task_prio[run_task]))
                        sw = 1;
                  end
               end
               next_wake = earliest_wake();
            end
            if (preempt_on && slice_on && run_valid && ready_count(task_prio[run_task]) > 1)
               sw = 1;
         end
         default: pick_task();
      endcase
      r.current_task = run_valid ? run_task : '0;
      r.current_valid = run_valid;
      r.switch_required = sw;
      r.tick_now = ticks;
      r.woken_count = COUNT_BITS'(woken);
      return r;
   endfunction

   function automatic int gap_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
   endfunction

   task automatic send_request(input logic [1:0] op, input logic [TASK_BITS-1:0] id,
         input logic [PRIO_BITS-1:0] pr, input logic [TICK_BITS-1:0] dly, input bit idle);
      int gap;
      gap = idle ? gap_length() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op <= op;
      req_chan.task_id <= id;
      req_chan.task_priority_in <= pr;
      req_chan.delay_ticks <= dly;
      do @(posedge clock); while (!req_chan.ready);
      pending_rsp.push_back(schedule_step(op, id, pr, dly));
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_PREEMPT) preempt_on = value;
      else slice_on = value;
   endtask

   // Response checker with a randomly stalling receiver.
   always @(posedge clock) begin
      sched_rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("outstanding requests", 32'd0, 32'd1);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_chan.current_task !== want.current_task)
               report_mismatch("current_task", 32'(rsp_chan.current_task),
                               32'(want.current_task));
            if (rsp_chan.current_valid !== want.current_valid)
               report_mismatch("current_valid", 32'(rsp_chan.current_valid),
                               32'(want.current_valid));
            if (rsp_chan.switch_required !== want.switch_required)
               report_mismatch("switch_required", 32'(rsp_chan.switch_required),
                               32'(want.switch_required));
            if (rsp_chan.tick_now !== want.tick_now)
               report_mismatch("tick_now", rsp_chan.tick_now, want.tick_now);
            if (rsp_chan.woken_count !== want.woken_count)
               report_mismatch("woken_count", 32'(rsp_chan.woken_count),
                               32'(want.woken_count));
         end
      end
      rsp_chan.ready <= stall_often ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic test_directed();
      send_request(OP_DELAY, 0, 0, 5, 0);
      send_request(OP_SWITCH, 0, 0, 0, 0);
      send_request(OP_TICK, 0, 0, 0, 0);
      send_request(OP_CREATE, 0, 0, 0, 0);
      send_request(OP_CREATE, 7, 7, '1, 0);
      send_request(OP_CREATE, 3, 7, 0, 0);
      send_request(OP_CREATE, 5, 2, 0, 0);
      send_request(OP_TICK, 0, 0, 0, 0);
      send_request(OP_SWITCH, 0, 0, 0, 0);
      send_request(OP_SWITCH, 0, 0, 0, 0);
      send_request(OP_DELAY, 0, 0, 0, 0);
      send_request(OP_DELAY, 0, 0, 2, 0);
      send_request(OP_DELAY, 0, 0, 32'hFFFF_FFFF, 0);
      send_request(OP_TICK, 0, 0, 0, 0);
      send_request(OP_TICK, 0, 0, 0, 0);
      send_request(OP_TICK, 0, 0, 0, 0);
      send_request(OP_CREATE, 7, 1, 0, 0);
      send_request(OP_SWITCH, 0, 0, 0, 0);
      send_request(OP_DELAY, 0, 0, 1, 0);
      send_request(OP_DELAY, 0, 0, 1, 0);
      send_request(OP_DELAY, 0, 0, 1, 0);
      send_request(OP_SWITCH, 0, 0, 0, 0);
      send_request(OP_TICK, 0, 0, 0, 0);
      send_request(OP_TICK, 0, 0, 0, 0);
   endtask

   task automatic test_random(input int count);
      logic [1:0] op;
      logic [TICK_BITS-1:0] dly;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0, 1:    op = OP_CREATE;
            2, 3:    op = OP_DELAY;
            4, 5, 6: op = OP_TICK;
            default: op = OP_SWITCH;
         endcase
         case ($urandom_range(0, 5))
            0:       dly = $urandom();
            1:       dly = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: dly = $urandom_range(0, 6);
         endcase
         send_request(op, TASK_BITS'($urandom_range(0, 7)), PRIO_BITS'($urandom_range(0, 7)),
                      dly, 1);
         if (n == count / 2) wait_drained();
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.op = OP_CREATE;
      req_chan.task_id = '0;
      req_chan.task_priority_in = '0;
      req_chan.delay_ticks = '0;
      clear_schedule();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      write_csr(CSR_PREEMPT, 1'b0);
      test_random(150);
      write_csr(CSR_PREEMPT, 1'b1);
      write_csr(CSR_TIME_SLICE, 1'b0);
      stall_often = 1'b1;
      test_random(150);
      write_csr(CSR_TIME_SLICE, 1'b1);
      stall_often = 1'b0;
      test_random(300);
      wait_drained();
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
sv/ptsched_pkg.sv
sv/ptsched_if.sv
sv/priority_task_scheduler_core.sv
verif/tb_priority_task_scheduler_core.sv
